// ----- rtl/core/bps_pkg.sv -----
// Package for the bitmap priority task scheduler.
// Holds sizes, opcode, status and state codes, and the channel and scan structs.
// No dependencies.
package bps_pkg;

  localparam int NUM_TASKS = 32;
  localparam int PID_W     = 5;
  localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int TIME_W    = 32;
  localparam int DELAY_W   = 31;

  localparam logic [NUM_TASKS-1:0] TASK_BIT0 = NUM_TASKS'(1);

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_SUSPEND = 3'd2,
    OP_RESUME  = 3'd3,
    OP_CHANGE  = 3'd4,
    OP_SLEEP   = 3'd5,
    OP_TICK    = 3'd6,
    OP_START   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_USED    = 2'd2,
    ST_NOTASK  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHG_WR,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t                opcode;
    logic [PID_W-1:0]   target_pid;
    logic [PID_W-1:0]   new_pid;
    logic [DELAY_W-1:0] delay_ticks;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic             switched;
    logic [PID_W-1:0] current_pid;
    logic             none_ready;
  } rsp_t;

  // One sleeper found due during the scan.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } scan_wake_t;

  // End of scan and the selected task.
  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] pid;
  } scan_done_t;

endpackage

// ----- rtl/core/bps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bps_scan.sv -----
// Wake-time scan engine: walks all task slots through one equality compare.
// Depends on bps_pkg; reads the wake-time RAM owned by the top level.
module bps_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [bps_pkg::NUM_TASKS-1:0]   ready_bits,
  input  logic [bps_pkg::NUM_TASKS-1:0]   sleep_bits,
  input  logic [bps_pkg::TIME_W-1:0]      tick_count,
  input  logic [bps_pkg::TIME_W-1:0]      ram_rdata,
  output logic [bps_pkg::IDX_W-1:0]       ram_raddr,
  output bps_pkg::scan_wake_t             wake,
  output bps_pkg::scan_done_t             done
);
  import bps_pkg::*;

  logic             busy;
  logic [IDX_W:0]   rd_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             best_found;
  logic [IDX_W-1:0] best_pid;

  logic issue;
  logic hit;
  logic rdy;
  logic last;

  // The compare sees each slot in the cycle after its read is issued.
  assign issue     = busy && (rd_idx < (IDX_W+1)'(NUM_TASKS));
  assign ram_raddr = rd_idx[IDX_W-1:0];

  // Shared compare: a sleeper whose wake time equals the tick count is due.
  assign hit  = cmp_valid && sleep_bits[cmp_idx] && (ram_rdata == tick_count);
  assign rdy  = cmp_valid && (ready_bits[cmp_idx] || hit);
  assign last = cmp_valid && (cmp_idx == IDX_W'(NUM_TASKS - 1));

  assign wake.hit   = hit;
  assign wake.idx   = cmp_idx;
  assign done.done  = last;
  assign done.found = best_found || rdy;
  assign done.pid   = rdy ? cmp_idx : best_pid;

  // Slots go in ascending order, so the last ready slot seen is the highest.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cmp_valid <= 1'b0;
    end else if (start) begin
      busy       <= 1'b1;
      rd_idx     <= '0;
      cmp_valid  <= 1'b0;
      best_found <= 1'b0;
    end else begin
      cmp_valid <= issue;
      if (issue) begin
        cmp_idx <= rd_idx[IDX_W-1:0];
        rd_idx  <= rd_idx + (IDX_W+1)'(1);
      end
      if (rdy) begin
        best_found <= 1'b1;
        best_pid   <= cmp_idx;
      end
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/bitmap_priority_task_scheduler_top.sv -----
// Top level of the bitmap priority task scheduler: event decode, task bitmaps,
// tick counter, sequencer and result register. Depends on bps_pkg, bps_ram, bps_scan.
//
//   Channel | Signals                    | Payload
//   --------+----------------------------+-----------------------------------
//   request | req_valid, req_ready, req  | opcode, target_pid, new_pid, delay
//   result  | rsp_valid, rsp_ready, rsp  | status, switched, current_pid, none
//
// An event without reselection goes from transfer through the response state to
// the result register. A reselecting event runs the wake-time scan, after a copy
// state for a change of priority of a sleeping task; the scan reads one RAM slot
// per cycle through a single compare. Reset clears all bitmaps, the tick count and
// the running task at once. The block takes a new request once the previous result
// is in the output register; a stalled result holds the next one back.
module bitmap_priority_task_scheduler_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  bps_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output bps_pkg::rsp_t   rsp
);
  import bps_pkg::*;

  state_t state, state_next;

  logic [NUM_TASKS-1:0] ready_bits, ready_next;
  logic [NUM_TASKS-1:0] present_bits, present_next;
  logic [NUM_TASKS-1:0] sleep_bits, sleep_next;
  logic [TIME_W-1:0]    tick_count, tick_next;
  logic                 started, started_next;
  logic [IDX_W-1:0]     running_pid;

  status_t              res_status;
  logic                 res_switched;
  logic                 res_none;
  logic [IDX_W-1:0]     np_reg;

  logic                 accept;
  logic                 tp_ok, np_ok;
  logic [IDX_W-1:0]     tp_idx, np_idx;
  logic [NUM_TASKS-1:0] tp_bit, np_bit, cur_bit;
  logic [TIME_W-1:0]    sum;
  status_t              status_d;
  logic                 sel_d;
  logic                 copy_d;
  logic                 sleep_wr_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [TIME_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [TIME_W-1:0]    ram_rdata;
  logic [IDX_W-1:0]     scan_raddr;
  logic                 scan_start;
  scan_wake_t           wake;
  scan_done_t           done;

  assign accept  = req_valid && req_ready;
  assign tp_ok   = ({1'b0, req.target_pid} < (PID_W+1)'(NUM_TASKS));
  assign np_ok   = ({1'b0, req.new_pid} < (PID_W+1)'(NUM_TASKS));
  assign tp_idx  = req.target_pid[IDX_W-1:0];
  assign np_idx  = req.new_pid[IDX_W-1:0];
  assign tp_bit  = TASK_BIT0 << tp_idx;
  assign np_bit  = TASK_BIT0 << np_idx;
  assign cur_bit = TASK_BIT0 << running_pid;

  // One adder serves both the tick increment and the wake-time sum.
  assign sum = tick_count + ((req.opcode == OP_TICK) ? TIME_W'(1) : TIME_W'(req.delay_ticks));

  // Event decode and bitmap updates. A wake time counts only while its
  // sleep bit is set, so clearing a wake time only clears the bit.
  always_comb begin
    ready_next   = ready_bits;
    present_next = present_bits;
    sleep_next   = sleep_bits;
    tick_next    = tick_count;
    started_next = started;
    status_d     = ST_OK;
    sel_d        = 1'b0;
    copy_d       = 1'b0;
    sleep_wr_d   = 1'b0;
    if (accept) begin
      case (req.opcode)
        OP_CREATE: begin
          if (!tp_ok) begin
            status_d = ST_ILLEGAL;
          end else if ((present_bits & tp_bit) != '0) begin
            status_d = ST_USED;
          end else begin
            present_next = present_bits | tp_bit;
            ready_next   = ready_bits | tp_bit;
            sleep_next   = sleep_bits & ~tp_bit;
            started_next = 1'b1;
          end
        end
        OP_DELETE: begin
          if (!tp_ok) begin
            status_d = ST_ILLEGAL;
          end else if ((present_bits & tp_bit) == '0) begin
            status_d = ST_NOTASK;
          end else if (req.target_pid == '0) begin
            status_d = ST_ILLEGAL;
          end else begin
            present_next = present_bits & ~tp_bit;
            ready_next   = ready_bits & ~tp_bit;
            sleep_next   = sleep_bits & ~tp_bit;
            sel_d        = (tp_idx == running_pid);
          end
        end
        OP_SUSPEND: begin
          if ((ready_bits & cur_bit) != '0) begin
            ready_next = ready_bits & ~cur_bit;
            sleep_next = sleep_bits & ~cur_bit;
            sel_d      = 1'b1;
          end
        end
        OP_RESUME: begin
          if (!tp_ok) begin
            status_d = ST_ILLEGAL;
          end else if ((present_bits & tp_bit) == '0) begin
            status_d = ST_NOTASK;
          end else if ((ready_bits & tp_bit) == '0) begin
            ready_next = ready_bits | tp_bit;
            sleep_next = sleep_bits & ~tp_bit;
            sel_d      = 1'b1;
          end
        end
        OP_CHANGE: begin
          if (!tp_ok || req.target_pid == '0) begin
            status_d = ST_ILLEGAL;
          end else if ((present_bits & tp_bit) == '0) begin
            status_d = ST_NOTASK;
          end else if (!np_ok) begin
            status_d = ST_ILLEGAL;
          end else if (tp_idx != np_idx) begin
            present_next = (present_bits & ~tp_bit) | np_bit;
            ready_next   = (ready_bits & ~tp_bit) | np_bit;
            sleep_next   = sleep_bits & ~tp_bit & ~np_bit;
            if ((sleep_bits & tp_bit) != '0) begin
              sleep_next = sleep_next | np_bit;
              copy_d     = 1'b1;
            end
            sel_d = 1'b1;
          end
        end
        OP_SLEEP: begin
          if (((present_bits & cur_bit) != '0) && running_pid != '0 &&
              req.delay_ticks != '0) begin
            sleep_wr_d = 1'b1;
            ready_next = ready_bits & ~cur_bit;
            // A sum that wraps to zero never wakes.
            if (sum != '0) begin
              sleep_next = sleep_bits | cur_bit;
            end else begin
              sleep_next = sleep_bits & ~cur_bit;
            end
            sel_d = 1'b1;
          end
        end
        OP_TICK: begin
          if (started) begin
            tick_next = sum;
            sel_d     = 1'b1;
          end
        end
        OP_START: begin
          if ((present_bits & TASK_BIT0) == '0) begin
            present_next = present_bits | TASK_BIT0;
            ready_next   = ready_bits | TASK_BIT0;
            sleep_next   = sleep_bits & ~TASK_BIT0;
          end
          started_next = 1'b1;
          sel_d        = 1'b1;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end else if (wake.hit) begin
      ready_next = ready_bits | (TASK_BIT0 << wake.idx);
      sleep_next = sleep_bits & ~(TASK_BIT0 << wake.idx);
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (copy_d) begin
            state_next = S_CHG_WR;
          end else if (sel_d) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_CHG_WR: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (done.done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: handshake, RAM port selection and scan start.
  always_comb begin
    req_ready  = 1'b0;
    scan_start = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = running_pid;
    ram_wdata  = sum;
    ram_raddr  = tp_idx;
    case (state)
      S_IDLE: begin
        req_ready  = 1'b1;
        ram_we     = accept && sleep_wr_d;
        scan_start = accept && sel_d && !copy_d;
      end
      S_CHG_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = np_reg;
        ram_wdata  = ram_rdata;
        scan_start = 1'b1;
      end
      S_SCAN: begin
        ram_raddr = scan_raddr;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // Control state and task bitmaps.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ready_bits   <= '0;
      present_bits <= '0;
      sleep_bits   <= '0;
      tick_count   <= '0;
      started      <= 1'b0;
      running_pid  <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      ready_bits   <= ready_next;
      present_bits <= present_next;
      sleep_bits   <= sleep_next;
      tick_count   <= tick_next;
      started      <= started_next;
      if (state == S_SCAN && done.done && done.found) begin
        running_pid <= done.pid;
      end
      if (state == S_RESP && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Per-event result fields and the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status   <= status_d;
      res_switched <= 1'b0;
      res_none     <= 1'b0;
      np_reg       <= np_idx;
    end
    if (state == S_SCAN && done.done) begin
      res_switched <= done.found;
      res_none     <= !done.found;
    end
    if (state == S_RESP && (!rsp_valid || rsp_ready)) begin
      rsp.status      <= res_status;
      rsp.switched    <= res_switched;
      rsp.current_pid <= PID_W'(running_pid);
      rsp.none_ready  <= res_none;
    end
  end

  bps_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_TASKS)
  ) u_wake_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bps_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (scan_start),
    .ready_bits (ready_bits),
    .sleep_bits (sleep_bits & present_bits),
    .tick_count (tick_count),
    .ram_rdata  (ram_rdata),
    .ram_raddr  (scan_raddr),
    .wake       (wake),
    .done       (done)
  );

endmodule
